// ===== src/run_length_byte_encoder_assert.svh =====
// Assertion helpers for the run-length byte encoder.
// Both sample on the rising edge of clock and stay quiet while reset is high.
`ifndef RUN_LENGTH_BYTE_ENCODER_ASSERT_SVH
`define RUN_LENGTH_BYTE_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLBE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Consequent must hold in the cycle after the antecedent.
`define RLBE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== src/rlbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rlbe_pkg;

   // Default sizing of the encoder
   localparam int LITERAL_MAX_DEF = 128;
   localparam int REPEAT_MAX_DEF  = 129;
   localparam int CHUNK_BYTES_DEF = 8;

   // Fixed field widths
   localparam int BYTE_W      = 8;
   localparam int MAX_LANES   = 8;
   localparam int CHUNK_W     = BYTE_W * MAX_LANES;
   localparam int COUNT_W     = 4;
   localparam int RSP_TDATA_W = 72;

   // One encoded byte handed from the sequencer to the chunk packer
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              final_byte;
      logic              stream_end;
   } pack_byte_type;

endpackage

`default_nettype wire

// ===== src/rlbe_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlbe_packer #(
   parameter int CHUNK_BYTES = rlbe_pkg::CHUNK_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rlbe_pkg::pack_byte_type        byte_in,
   output logic                                byte_ready,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // bits 63:0 chunk_data, 67:64 chunk_count, 71:68 zero
   output logic [rlbe_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   // bit 0 stream_done
   output logic                                rsp_tuser
);
   import rlbe_pkg::*;

   logic [CHUNK_W-1:0] asm_data_ff, asm_data_in;
   logic [COUNT_W-1:0] asm_cnt_ff, asm_cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHUNK_W-1:0] out_data_ff, out_data_in;
   logic [COUNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic               out_last_ff, out_last_in;
   logic               out_done_ff, out_done_in;

   logic [CHUNK_W-1:0] merged;
   logic               close_chunk;
   logic               out_free;
   logic               take;

   // Drop the new byte into its lane of the word being gathered
   always_comb begin
      merged = asm_data_ff;
      for (int i = 0; i < MAX_LANES; i++) begin
         if (asm_cnt_ff == COUNT_W'(i)) begin
            merged[BYTE_W*i +: BYTE_W] = byte_in.data;
         end
      end
   end

   assign close_chunk = byte_in.final_byte || (asm_cnt_ff == COUNT_W'(CHUNK_BYTES - 1));
   assign out_free    = !out_valid_ff || rsp_tready;
   assign byte_ready  = !close_chunk || out_free;
   assign take        = byte_in.valid && byte_ready;

   // Gather bytes and hand a full or final word to the output register
   always_comb begin
      asm_data_in  = asm_data_ff;
      asm_cnt_in   = asm_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (take) begin
         if (close_chunk) begin
            out_valid_in = 1'b1;
            out_data_in  = merged;
            out_cnt_in   = asm_cnt_ff + COUNT_W'(1);
            out_last_in  = byte_in.final_byte;
            out_done_in  = byte_in.final_byte && byte_in.stream_end;
            asm_data_in  = '0;
            asm_cnt_in   = '0;
         end else begin
            asm_data_in  = merged;
            asm_cnt_in   = asm_cnt_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_data_ff  <= '0;
         asm_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         asm_data_ff  <= asm_data_in;
         asm_cnt_ff   <= asm_cnt_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - CHUNK_W - COUNT_W){1'b0}}, out_cnt_ff, out_data_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

endmodule

`default_nettype wire

// ===== src/run_length_byte_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "run_length_byte_encoder_assert.svh"
//  channel | direction | tdata                               | tlast       | tuser
//  req     | in        | 7:0 data_byte                       | stream_end  | -
//  rsp     | out       | 63:0 chunk_data, 67:64 chunk_count  | chunk_last  | stream_done
//
//  A byte that emits nothing leaves req_tready high. A byte that emits encoded bytes keeps
//  req_tready low until they are out: the sequencer passes one byte per cycle, while the
//  packer is ready, pacing the literal store's single read port during a literal flush.
//  Reset is synchronous; it clears the run state, the store contents stay as they were.
//  A stalled rsp holds the packer and the sequencer; req_tready drops while a code is out.

module run_length_byte_encoder #(
   parameter int LITERAL_MAX = rlbe_pkg::LITERAL_MAX_DEF,
   parameter int REPEAT_MAX  = rlbe_pkg::REPEAT_MAX_DEF,
   parameter int CHUNK_BYTES = rlbe_pkg::CHUNK_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // bits 7:0 data_byte
   input  wire logic [7:0]                     req_tdata,
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // bits 63:0 chunk_data, 67:64 chunk_count, 71:68 zero
   output logic [rlbe_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   // bit 0 stream_done
   output logic                                rsp_tuser
);
   import rlbe_pkg::*;

   localparam int AW = $clog2(LITERAL_MAX);
   localparam int RW = $clog2(REPEAT_MAX + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_HEAD, ST_BODY, ST_TAIL} state_type;

   // One code group: header, stored literal bytes, then an optional closing byte
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] head;
      logic [AW-1:0]     nbody;
      logic              tail;
      logic [BYTE_W-1:0] tail_byte;
   } seg_type;

   function automatic logic [BYTE_W-1:0] lit_head(input logic [BYTE_W-1:0] n);
      logic [BYTE_W-1:0] m;
      m = n - BYTE_W'(1);
      return {m[BYTE_W-2:0], 1'b1};
   endfunction

   function automatic logic [BYTE_W-1:0] run_head(input logic [BYTE_W-1:0] r);
      logic [BYTE_W-1:0] m;
      m = r - BYTE_W'(2);
      return {m[BYTE_W-2:0], 1'b0};
   endfunction

   state_type         state_ff, state_in;
   logic [AW-1:0]     idx_ff, idx_in;
   seg_type           cur_ff, cur_in;
   seg_type           nxt_ff, nxt_in;
   logic [AW-1:0]     lit_cnt_ff, lit_cnt_in;
   logic [RW-1:0]     rep_cnt_ff, rep_cnt_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic              started_ff, started_in;

   logic [BYTE_W-1:0] store_mem [LITERAL_MAX];
   logic [BYTE_W-1:0] mem_rd_ff;
   logic              mem_we;

   logic              accept;
   logic              stream_end;
   logic [BYTE_W-1:0] t_byte;
   logic [BYTE_W-1:0] lit8;
   logic [BYTE_W-1:0] rep8;
   seg_type           seg_a, seg_b;
   logic              seg_last;
   logic              advance;
   logic              byte_ready;
   pack_byte_type     pack_byte;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign t_byte     = req_tdata;
   assign stream_end = req_tlast;
   assign lit8       = BYTE_W'(lit_cnt_ff);
   assign rep8       = BYTE_W'(rep_cnt_ff);

   // Plan the code groups an incoming byte causes and the run state it leaves
   always_comb begin
      seg_a      = '0;
      seg_b      = '0;
      mem_we     = 1'b0;
      lit_cnt_in = lit_cnt_ff;
      rep_cnt_in = rep_cnt_ff;
      held_in    = held_ff;
      started_in = started_ff;
      if (!started_ff) begin
         held_in    = t_byte;
         lit_cnt_in = '0;
         rep_cnt_in = '0;
         started_in = 1'b1;
         seg_b      = '{1'b1, lit_head(BYTE_W'(1)), '0, 1'b1, t_byte};
      end else if (t_byte == held_ff) begin
         if (rep_cnt_ff == '0) begin
            if (lit_cnt_ff != '0) begin
               seg_a = '{1'b1, lit_head(lit8), lit_cnt_ff, 1'b0, held_ff};
            end
            lit_cnt_in = '0;
            rep_cnt_in = RW'(2);
            seg_b      = '{1'b1, run_head(BYTE_W'(2)), '0, 1'b1, held_ff};
         end else if (rep_cnt_ff < RW'(REPEAT_MAX)) begin
            rep_cnt_in = rep_cnt_ff + RW'(1);
            seg_b      = '{1'b1, run_head(rep8 + BYTE_W'(1)), '0, 1'b1, held_ff};
         end else begin
            seg_a      = '{1'b1, run_head(rep8), '0, 1'b1, held_ff};
            rep_cnt_in = '0;
            seg_b      = '{1'b1, lit_head(BYTE_W'(1)), '0, 1'b1, held_ff};
         end
      end else begin
         held_in = t_byte;
         if (rep_cnt_ff != '0) begin
            seg_a      = '{1'b1, run_head(rep8), '0, 1'b1, held_ff};
            lit_cnt_in = '0;
            rep_cnt_in = '0;
            seg_b      = '{1'b1, lit_head(BYTE_W'(1)), '0, 1'b1, t_byte};
         end else if (lit_cnt_ff < AW'(LITERAL_MAX - 1)) begin
            mem_we     = accept;
            lit_cnt_in = lit_cnt_ff + AW'(1);
            seg_b      = '{1'b1, lit_head(lit8 + BYTE_W'(2)), lit_cnt_ff + AW'(1), 1'b1,
                           t_byte};
         end else begin
            seg_a      = '{1'b1, lit_head(lit8 + BYTE_W'(1)), lit_cnt_ff, 1'b1, held_ff};
            lit_cnt_in = '0;
            seg_b      = '{1'b1, lit_head(BYTE_W'(1)), '0, 1'b1, t_byte};
         end
      end
      // The flush groups only apply at stream end, which also rearms the encoder
      if (stream_end) begin
         lit_cnt_in = '0;
         rep_cnt_in = '0;
         held_in    = '0;
         started_in = 1'b0;
      end else begin
         seg_b = '0;
      end
      // Close up the gap when no first group exists
      if (!seg_a.valid) begin
         seg_a = seg_b;
         seg_b = '0;
      end
   end

   // Last byte of the current group, judged from the step it is on
   always_comb begin
      case (state_ff)
         ST_HEAD: seg_last = (cur_ff.nbody == '0) && !cur_ff.tail;
         ST_BODY: seg_last = (idx_ff == cur_ff.nbody - AW'(1)) && !cur_ff.tail;
         ST_TAIL: seg_last = 1'b1;
         default: seg_last = 1'b0;
      endcase
   end

   // Drive the packer with the byte of the current step
   always_comb begin
      pack_byte.valid      = (state_ff != ST_IDLE);
      pack_byte.final_byte = seg_last && !nxt_ff.valid;
      pack_byte.stream_end = !started_ff;
      case (state_ff)
         ST_HEAD: pack_byte.data = cur_ff.head;
         ST_BODY: pack_byte.data = mem_rd_ff;
         ST_TAIL: pack_byte.data = cur_ff.tail_byte;
         default: pack_byte.data = '0;
      endcase
   end

   assign advance = pack_byte.valid && byte_ready;

   // Step through header, stored bytes and closing byte; idx_in is the next read address
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      nxt_in   = nxt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && seg_a.valid) begin
               cur_in   = seg_a;
               nxt_in   = seg_b;
               state_in = ST_HEAD;
               idx_in   = '0;
            end
         end
         ST_HEAD, ST_BODY, ST_TAIL: begin
            if (advance) begin
               if (seg_last) begin
                  idx_in = '0;
                  if (nxt_ff.valid) begin
                     cur_in       = nxt_ff;
                     nxt_in.valid = 1'b0;
                     state_in     = ST_HEAD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (state_ff == ST_HEAD) begin
                  if (cur_ff.nbody != '0) begin
                     state_in = ST_BODY;
                     idx_in   = '0;
                  end else begin
                     state_in = ST_TAIL;
                  end
               end else if (idx_ff == cur_ff.nbody - AW'(1)) begin
                  state_in = ST_TAIL;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold sequencer and run state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff.valid <= 1'b0;
         nxt_ff.valid <= 1'b0;
         lit_cnt_ff   <= '0;
         rep_cnt_ff   <= '0;
         held_ff      <= '0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff.valid <= cur_in.valid;
         nxt_ff.valid <= nxt_in.valid;
         if (accept) begin
            lit_cnt_ff <= lit_cnt_in;
            rep_cnt_ff <= rep_cnt_in;
            held_ff    <= held_in;
            started_ff <= started_in;
         end
      end
      idx_ff           <= idx_in;
      cur_ff.head      <= cur_in.head;
      cur_ff.nbody     <= cur_in.nbody;
      cur_ff.tail      <= cur_in.tail;
      cur_ff.tail_byte <= cur_in.tail_byte;
      nxt_ff.head      <= nxt_in.head;
      nxt_ff.nbody     <= nxt_in.nbody;
      nxt_ff.tail      <= nxt_in.tail;
      nxt_ff.tail_byte <= nxt_in.tail_byte;
   end

   // Literal store: one write port, one registered read port. The read is reissued every
   // cycle, so a byte written on accept is read back from the header step onward.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[lit_cnt_ff] <= held_ff;
      end
      mem_rd_ff <= store_mem[idx_in];
   end

   rlbe_packer #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_packer (
      .clock      (clock),
      .reset      (reset),
      .byte_in    (pack_byte),
      .byte_ready (byte_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // A run and pending literals never coexist
   `RLBE_ASSERT_SAME(a_run_excl_lit, rep_cnt_ff != '0, lit_cnt_ff == '0)
   // A stream end always flushes and rearms
   `RLBE_ASSERT_NEXT(a_end_flush, accept && stream_end, !started_ff && (state_ff != ST_IDLE))
   // A byte refused by the packer stays put, memory read included
   `RLBE_ASSERT_NEXT(a_stall_hold, pack_byte.valid && !byte_ready,
                     pack_byte.valid && $stable(pack_byte.data))
   // Output words carry one to CHUNK_BYTES bytes
   `RLBE_ASSERT_SAME(a_count_range, rsp_tvalid,
                     (rsp_tdata[67:64] != '0) && (rsp_tdata[67:64] <= COUNT_W'(CHUNK_BYTES)))

endmodule

`default_nettype wire

// ===== tb/run_length_byte_encoder_checker.sv =====
`timescale 1ns / 1ps

module run_length_byte_encoder_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   // bits 7:0 data_byte
   input  wire logic [7:0]                       req_tdata,
   input  wire logic                             req_tlast,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // bits 63:0 chunk_data, 67:64 chunk_count, 71:68 zero
   input  wire logic [rlbe_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                             rsp_tlast,
   // bit 0 stream_done
   input  wire logic                             rsp_tuser,
   output int                                    fail_count,
   output int                                    chunks_waiting,
   output int                                    chunks_checked
);
   import rlbe_pkg::*;

   localparam int LITERAL_LIMIT = LITERAL_MAX_DEF;
   localparam int REPEAT_LIMIT  = REPEAT_MAX_DEF;
   localparam int CHUNK_LANES   = CHUNK_BYTES_DEF;
   localparam int REPORT_LIMIT  = 40;

   typedef struct packed {
      logic [CHUNK_W-1:0] data;
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               done;
   } code_chunk_type;

   // Encoder state as seen from outside
   logic [7:0]  literal_bytes [LITERAL_LIMIT];
   int          literal_fill;
   int          run_length;
   logic [7:0]  held_value;
   logic        stream_open;

   logic [7:0]     code_bytes [$];
   code_chunk_type expected_chunks [$];

   initial begin
      fail_count     = 0;
      chunks_waiting = 0;
      chunks_checked = 0;
      literal_fill   = 0;
      run_length     = 0;
      held_value     = 8'h00;
      stream_open    = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      // keep the log short when the design is badly off
      if (fail_count < REPORT_LIMIT)
         $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   // Literal header and the stored bytes, with or without the held byte
   task automatic put_literal_run(input bit with_held);
      logic [7:0] header;
      int         n;
      int         i;
      n = literal_fill + (with_held ? 1 : 0);
      header = 8'(((n - 1) << 1) | 1);
      code_bytes.push_back(header);
      for (i = 0; i < literal_fill; i++)
         code_bytes.push_back(literal_bytes[i]);
      if (with_held)
         code_bytes.push_back(held_value);
      literal_fill = 0;
   endtask

   task automatic put_repeat_run();
      logic [7:0] header;
      header = 8'((run_length - 2) << 1);
      code_bytes.push_back(header);
      code_bytes.push_back(held_value);
      run_length = 0;
   endtask

   // Absorb one byte and work out the code it releases
   task automatic encode_byte(input logic [7:0] value, input logic end_mark);
      code_bytes.delete();
      if (!stream_open) begin
         held_value   = value;
         literal_fill = 0;
         run_length   = 0;
         stream_open  = 1'b1;
      end else if (value == held_value) begin
         if (run_length == 0) begin
            // a run starts: stored literals leave first, held byte excluded
            if (literal_fill > 0)
               put_literal_run(1'b0);
            run_length = 2;
         end else if (run_length < REPEAT_LIMIT) begin
            run_length++;
         end else begin
            put_repeat_run();
         end
      end else begin
         if (run_length != 0) begin
            put_repeat_run();
            literal_fill = 0;
         end else if (literal_fill + 1 < LITERAL_LIMIT) begin
            literal_bytes[literal_fill] = held_value;
            literal_fill++;
         end else begin
            put_literal_run(1'b1);
         end
         held_value = value;
      end

      // flush whatever is pending and wait for a new stream
      if (end_mark) begin
         if (run_length != 0)
            put_repeat_run();
         else
            put_literal_run(1'b1);
         literal_fill = 0;
         run_length   = 0;
         held_value   = 8'h00;
         stream_open  = 1'b0;
      end
   endtask

   // Split the released code into chunks of up to eight bytes
   task automatic queue_chunks(input logic end_mark);
      code_chunk_type chunk;
      int             pos;
      int             lane;
      int             lanes;
      for (pos = 0; pos < code_bytes.size(); pos += CHUNK_LANES) begin
         lanes = code_bytes.size() - pos;
         if (lanes > CHUNK_LANES)
            lanes = CHUNK_LANES;
         chunk = '0;
         for (lane = 0; lane < lanes; lane++)
            chunk.data[lane*8 +: 8] = code_bytes[pos + lane];
         chunk.count = COUNT_W'(lanes);
         chunk.last  = (pos + lanes >= code_bytes.size());
         chunk.done  = chunk.last && end_mark;
         expected_chunks.push_back(chunk);
      end
   endtask

   // Predict on each accepted byte, compare each accepted chunk
   always @(posedge clock) begin : watch
      code_chunk_type want;
      if (reset) begin
         literal_fill = 0;
         run_length   = 0;
         held_value   = 8'h00;
         stream_open  = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
            queue_chunks(req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chunks.size() == 0) begin
               report_mismatch("chunk with nothing expected", rsp_tdata[CHUNK_W-1:0], '0);
            end else begin
               want = expected_chunks.pop_front();
               if (rsp_tdata[CHUNK_W-1:0] !== want.data)
                  report_mismatch("chunk_data", rsp_tdata[CHUNK_W-1:0], want.data);
               if (rsp_tdata[CHUNK_W +: COUNT_W] !== want.count)
                  report_mismatch("chunk_count", 64'(rsp_tdata[CHUNK_W +: COUNT_W]),
                                  64'(want.count));
               if (rsp_tlast !== want.last)
                  report_mismatch("chunk_last", 64'(rsp_tlast), 64'(want.last));
               if (rsp_tuser !== want.done)
                  report_mismatch("stream_done", 64'(rsp_tuser), 64'(want.done));
               chunks_checked++;
            end
         end
      end
      chunks_waiting = expected_chunks.size();
   end

endmodule

// ===== tb/run_length_byte_encoder_test.sv =====
`timescale 1ns / 1ps

module run_length_byte_encoder_test;
   import rlbe_pkg::*;

   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 300;
   localparam int RANDOM_BYTES     = 100;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;

   int                     fail_count;
   int                     chunks_waiting;
   int                     chunks_checked;
   int                     bytes_sent;
   int                     streams_sent;
   logic                   req_steady;
   logic                   long_hold_req;
   logic [7:0]             stream_bytes [$];

   run_length_byte_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   run_length_byte_encoder_checker code_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .fail_count     (fail_count),
      .chunks_waiting (chunks_waiting),
      .chunks_checked (chunks_checked)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Offer one word and hold it until taken; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] value, input logic end_mark);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tlast  = end_mark;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_stream();
      int i;
      for (i = 0; i < stream_bytes.size(); i++)
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      streams_sent++;
   endtask

   // Pause the sender until every expected chunk is back
   task automatic wait_for_drain();
      req_tvalid = 1'b0;
      while (chunks_waiting != 0)
         @(negedge clock);
   endtask

   // Each byte differs from the one before it
   task automatic fill_literal_span(input int count, input logic [7:0] start);
      logic [7:0] value;
      int         i;
      stream_bytes.delete();
      value = start;
      for (i = 0; i < count; i++) begin
         stream_bytes.push_back(value);
         value = value + 8'd3;
      end
   endtask

   // Runs and literals with random content, or noise from a tiny alphabet
   task automatic build_random_stream(input int target);
      logic [7:0] value;
      int         seg;
      int         k;
      bit         noise;
      stream_bytes.delete();
      noise = ($urandom_range(0, 99) < 15);
      while (stream_bytes.size() < target) begin
         value = 8'($urandom_range(0, 255));
         if (noise) begin
            stream_bytes.push_back(8'($urandom_range(0, 3)));
         end else if ($urandom_range(0, 99) < 50) begin
            seg = $urandom_range(2, 7);
            repeat (seg)
               stream_bytes.push_back(value);
         end else begin
            seg = $urandom_range(1, 5);
            for (k = 0; k < seg; k++) begin
               stream_bytes.push_back(value);
               value = value + 8'($urandom_range(1, 255));
            end
         end
      end
   endtask

   // Output side: random back-pressure, quiet stretches, one long hold
   initial begin : receiver
      int hold_left;
      bit long_hold_done;
      bit rsp_steady;
      rsp_tready     = 1'b0;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_steady     = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 149) == 0)
            rsp_steady = !rsp_steady;
         if (long_hold_req && !long_hold_done) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else if (hold_left == 0 && !rsp_steady && $urandom_range(0, 99) < 30) begin
            hold_left = pick_gap();
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin : stimulus
      int random_bytes;
      int target;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      req_steady    = 1'b0;
      long_hold_req = 1'b0;
      bytes_sent    = 0;
      streams_sent  = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // lone bytes at both extremes, shortest run, literal before a run,
      // run then lone byte, two-byte literal, literal spread over two words
      stream_bytes = '{8'h00};
      send_stream();
      stream_bytes = '{8'hFF};
      send_stream();
      stream_bytes = '{8'hA5, 8'hA5};
      send_stream();
      stream_bytes = '{8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04};
      send_stream();
      stream_bytes = '{8'h7E, 8'h7E, 8'h81};
      send_stream();
      stream_bytes = '{8'h10, 8'h20};
      send_stream();
      fill_literal_span(9, 8'h40);
      send_stream();
      wait_for_drain();

      // keep offering while the receiver holds off, so the block backs up
      long_hold_req = 1'b1;
      req_steady    = 1'b1;
      build_random_stream(40);
      send_stream();
      random_bytes = stream_bytes.size();

      while (random_bytes < RANDOM_BYTES) begin
         target = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(1, 12);
         build_random_stream(target);
         req_steady = ($urandom_range(0, 3) == 0);
         send_stream();
         random_bytes += stream_bytes.size();
         if (streams_sent % 4 == 0)
            wait_for_drain();
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d bytes in %0d streams; %0d chunks compared, %0d mismatches.",
               bytes_sent, streams_sent, chunks_checked, fail_count);
      $display("Covered lone bytes, short runs and literals, a %0d-cycle output hold and drains.",
               LONG_HOLD_CYCLES);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
